// ===== rtl/core/sipf_pkg.sv =====
// Shared types, protocol constants and command tables for the servo
// instruction packet framer. No dependencies; imported by every module.
package sipf_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned IdxW    = 4;   // byte index, packets are at most 11 bytes
    localparam int unsigned NparW   = 3;   // parameter count, at most 5
    localparam int unsigned ReplyW  = 4;
    localparam int unsigned OpW     = 3;
    localparam int unsigned ValueW  = 16;
    localparam int unsigned HdrLen  = 5;   // two start bytes, id, length, instruction

    localparam logic [ByteW-1:0] START_BYTE   = 8'hFF;
    localparam logic [ByteW-1:0] BROADCAST_ID = 8'hFE;
    localparam logic [ByteW-1:0] INSTR_READ   = 8'h02;
    localparam logic [ByteW-1:0] INSTR_WRITE  = 8'h03;
    localparam logic [ByteW-1:0] INSTR_RESET  = 8'h06;

    localparam logic [ByteW-1:0] ADDR_ID        = 8'h03;
    localparam logic [ByteW-1:0] ADDR_ALARM     = 8'h12;
    localparam logic [ByteW-1:0] ADDR_TORQUE_EN = 8'h18;
    localparam logic [ByteW-1:0] ADDR_TORQUE_LM = 8'h22;
    localparam logic [ByteW-1:0] ADDR_PRESENT   = 8'h24;
    localparam logic [ByteW-1:0] ADDR_GOAL      = 8'h1E;
    localparam logic [ByteW-1:0] ADDR_MOVING    = 8'h2E;
    localparam logic [ByteW-1:0] ALARM_MASK     = 8'h24;

    typedef enum logic [OpW-1:0] {
        OP_GOTO        = 3'd0,
        OP_READ_MOVING = 3'd1,
        OP_READ_POS    = 3'd2,
        OP_ALARM       = 3'd3,
        OP_TORQUE_ON   = 3'd4,
        OP_TORQUE_LIM  = 3'd5,
        OP_SET_ID      = 3'd6,
        OP_RESET       = 3'd7
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic load;   // capture a new command
        logic emit;   // send the byte at the current index
    } t_dp_cmd;

    typedef struct packed {
        logic last;   // current index is the checksum byte
    } t_dp_status;

    function automatic logic [ByteW-1:0] op_instr(input t_op op);
        case (op)
            OP_READ_MOVING, OP_READ_POS: op_instr = INSTR_READ;
            OP_RESET:                    op_instr = INSTR_RESET;
            default:                     op_instr = INSTR_WRITE;
        endcase
    endfunction

    function automatic logic [NparW-1:0] op_nparam(input t_op op);
        case (op)
            OP_GOTO:                      op_nparam = 3'd5;
            OP_TORQUE_ON, OP_TORQUE_LIM:  op_nparam = 3'd3;
            OP_RESET:                     op_nparam = 3'd0;
            default:                      op_nparam = 3'd2;
        endcase
    endfunction

    function automatic logic [ReplyW-1:0] op_reply(input t_op op);
        case (op)
            OP_READ_MOVING:     op_reply = 4'd7;
            OP_READ_POS:        op_reply = 4'd8;
            OP_ALARM, OP_RESET: op_reply = 4'd0;
            default:            op_reply = 4'd6;
        endcase
    endfunction

    function automatic logic [ByteW-1:0] op_param(
        input t_op              op,
        input logic [ValueW-1:0] va,
        input logic [ValueW-1:0] vb,
        input logic [NparW-1:0]  k
    );
        logic [ByteW-1:0] p;
        p = 8'h00;
        case (op)
            OP_GOTO: begin
                case (k)
                    3'd0:    p = ADDR_GOAL;
                    3'd1:    p = va[7:0];
                    3'd2:    p = va[15:8];
                    3'd3:    p = vb[7:0];
                    default: p = vb[15:8];
                endcase
            end
            OP_READ_MOVING: p = (k == 3'd0) ? ADDR_MOVING : 8'h01;
            OP_READ_POS:    p = (k == 3'd0) ? ADDR_PRESENT : 8'h02;
            OP_ALARM:       p = (k == 3'd0) ? ADDR_ALARM : ALARM_MASK;
            OP_TORQUE_ON: begin
                case (k)
                    3'd0:    p = ADDR_TORQUE_EN;
                    3'd1:    p = 8'h01;
                    default: p = 8'h00;
                endcase
            end
            OP_TORQUE_LIM: begin
                case (k)
                    3'd0:    p = ADDR_TORQUE_LM;
                    3'd1:    p = va[7:0];
                    default: p = va[15:8];
                endcase
            end
            OP_SET_ID:      p = (k == 3'd0) ? ADDR_ID : va[7:0];
            default:        p = 8'h00;
        endcase
        op_param = p;
    endfunction

endpackage

// ===== rtl/core/servo_instruction_packet_framer_top.sv =====
// Servo instruction packet framer, top level: sequencer plus datapath.
// Depends on sipf_pkg, sipf_ctrl and sipf_dp.
//
// Pulse start while busy is low to frame one command. The packet then
// comes out one byte per cycle on o_tx_byte, each byte marked by o_strobe
// for a single cycle, once the sequencer state and the datapath output
// register have taken the start; the checksum byte carries o_last_byte.
// The receiver cannot stall, so it must take every strobed byte. Busy stays
// high while the packet is sent, from 6 bytes for factory reset up to 11
// for goal position with speed; a new start is taken only after that.
module servo_instruction_packet_framer_top
    import sipf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OpW-1:0]    i_operation,
    input  logic [ByteW-1:0]  i_servo_id,
    input  logic [ValueW-1:0] i_value_a,
    input  logic [ValueW-1:0] i_value_b,
    output logic              o_strobe,
    output logic [ByteW-1:0]  o_tx_byte,
    output logic              o_last_byte,
    output logic [ReplyW-1:0] o_reply_length
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sipf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sipf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_operation),
        .i_servo_id     (i_servo_id),
        .i_value_a      (i_value_a),
        .i_value_b      (i_value_b),
        .o_status       (status),
        .o_strobe       (o_strobe),
        .o_tx_byte      (o_tx_byte),
        .o_last_byte    (o_last_byte),
        .o_reply_length (o_reply_length)
    );

endmodule

// ===== rtl/core/sipf_ctrl.sv =====
// Sequencer for the packet framer: idle/send state machine.
// Depends on sipf_pkg for the state enum and command/status structs.
module sipf_ctrl
    import sipf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_busy     = 1'b0;
        case (r_state)
            ST_IDLE: o_cmd.load = i_start;
            ST_SEND: begin
                o_cmd.emit = 1'b1;
                o_busy     = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/sipf_dp.sv =====
// Datapath for the packet framer: command capture, byte index, running
// checksum and output register. Depends on sipf_pkg for tables and structs.
module sipf_dp
    import sipf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [OpW-1:0]    i_operation,
    input  logic [ByteW-1:0]  i_servo_id,
    input  logic [ValueW-1:0] i_value_a,
    input  logic [ValueW-1:0] i_value_b,
    output t_dp_status        o_status,
    output logic              o_strobe,
    output logic [ByteW-1:0]  o_tx_byte,
    output logic              o_last_byte,
    output logic [ReplyW-1:0] o_reply_length
);

    t_op               r_op;
    logic [ByteW-1:0]  r_id;
    logic [ValueW-1:0] r_va;
    logic [ValueW-1:0] r_vb;
    logic [IdxW-1:0]   r_idx;
    logic [ByteW-1:0]  r_sum;
    logic              r_strobe;
    logic [ByteW-1:0]  r_tx_byte;
    logic              r_last_byte;
    logic [ReplyW-1:0] r_reply;

    logic [NparW-1:0]  nparam;
    logic [IdxW-1:0]   last_idx;
    logic [IdxW-1:0]   par_idx;
    logic              is_last;
    logic [ByteW-1:0]  n_byte;

    assign nparam   = op_nparam(r_op);
    assign last_idx = {1'b0, nparam} + IdxW'(HdrLen);
    assign par_idx  = r_idx - IdxW'(HdrLen);
    assign is_last  = (r_idx == last_idx);
    assign o_status.last = is_last;

    always_comb begin
        if (is_last) begin
            n_byte = ~r_sum;
        end else begin
            case (r_idx)
                4'd0, 4'd1: n_byte = START_BYTE;
                4'd2:       n_byte = r_id;
                4'd3:       n_byte = {{(ByteW-NparW){1'b0}}, nparam} + 8'd2;
                4'd4:       n_byte = op_instr(r_op);
                default:    n_byte = op_param(r_op, r_va, r_vb, par_idx[NparW-1:0]);
            endcase
        end
    end

    // Capture the command; set id always goes out on the broadcast id.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_op'(i_operation);
            r_id <= (t_op'(i_operation) == OP_SET_ID) ? BROADCAST_ID : i_servo_id;
            r_va <= i_value_a;
            r_vb <= i_value_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    // Accumulate from the id byte onward; start bytes stay out of the sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum <= '0;
        end else if (i_cmd.emit && (r_idx >= 4'd2)) begin
            r_sum <= r_sum + n_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_tx_byte   <= n_byte;
            r_last_byte <= is_last;
            r_reply     <= op_reply(r_op);
        end
    end

    assign o_strobe       = r_strobe;
    assign o_tx_byte      = r_tx_byte;
    assign o_last_byte    = r_last_byte;
    assign o_reply_length = r_reply;

endmodule

// ===== tb/sv/servo_instruction_packet_framer_top_test.sv =====
// Self-checking testbench for servo_instruction_packet_framer_top.
// Depends on sipf_pkg; predicts every packet byte and compares the strobed
// bytes against it, after a table of directed commands and random ones.
`timescale 1ns / 1ps

module servo_instruction_packet_framer_top_test;
    import sipf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 150;   // per idling phase
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [ByteW-1:0]  data;
        logic              last;
        logic [ReplyW-1:0] reply;
    } t_tx_beat;

    // One directed command; chk_known marks a checksum typed in by hand.
    typedef struct packed {
        t_op               op;
        logic [ByteW-1:0]  id;
        logic [ValueW-1:0] va;
        logic [ValueW-1:0] vb;
        logic              chk_known;
        logic [ByteW-1:0]  chk;
    } t_cmd_row;

    localparam int NUM_DIRECTED = 24;

    t_cmd_row directed_cmds [NUM_DIRECTED] = '{
        '{OP_RESET,       8'h00, 16'h0000, 16'h0000, 1'b1, 8'hF7},
        '{OP_RESET,       8'hFE, 16'hFFFF, 16'hFFFF, 1'b1, 8'hF9},
        '{OP_RESET,       8'hFF, 16'h0000, 16'h0000, 1'b1, 8'hF8},
        '{OP_GOTO,        8'h00, 16'h0000, 16'h0000, 1'b1, 8'hD7},
        '{OP_GOTO,        8'h01, 16'hFFFF, 16'hFFFF, 1'b1, 8'hDA},
        '{OP_GOTO,        8'hFE, 16'h1234, 16'h5678, 1'b0, 8'h00},
        '{OP_READ_MOVING, 8'h01, 16'h0000, 16'h0000, 1'b1, 8'hC9},
        '{OP_READ_MOVING, 8'hFE, 16'h0000, 16'h0000, 1'b0, 8'h00},
        '{OP_READ_POS,    8'h01, 16'h0000, 16'h0000, 1'b1, 8'hD2},
        '{OP_READ_POS,    8'hFF, 16'hFFFF, 16'h0000, 1'b0, 8'h00},
        '{OP_ALARM,       8'h00, 16'hFFFF, 16'hFFFF, 1'b1, 8'hC2},
        '{OP_TORQUE_ON,   8'h01, 16'h0000, 16'h0000, 1'b1, 8'hDD},
        '{OP_TORQUE_ON,   8'h20, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00},
        '{OP_TORQUE_ON,   8'hFE, 16'h0000, 16'h0000, 1'b0, 8'h00},
        '{OP_TORQUE_LIM,  8'h01, 16'h03FF, 16'h0000, 1'b1, 8'hD2},
        '{OP_TORQUE_LIM,  8'h00, 16'h0000, 16'hFFFF, 1'b0, 8'h00},
        '{OP_TORQUE_LIM,  8'hFF, 16'hFFFF, 16'h0000, 1'b0, 8'h00},
        '{OP_SET_ID,      8'h05, 16'h0001, 16'h0000, 1'b1, 8'hF6},
        '{OP_SET_ID,      8'h05, 16'hFF00, 16'hFFFF, 1'b1, 8'hF7},
        '{OP_SET_ID,      8'hFF, 16'h00FE, 16'h0000, 1'b0, 8'h00},
        '{OP_GOTO,        8'hFF, 16'h8001, 16'h7FFE, 1'b0, 8'h00},
        '{OP_ALARM,       8'hFE, 16'h0000, 16'h0000, 1'b0, 8'h00},
        '{OP_READ_MOVING, 8'h00, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00},
        '{OP_GOTO,        8'hAA, 16'h5555, 16'hAAAA, 1'b0, 8'h00}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OpW-1:0]    i_operation;
    logic [ByteW-1:0]  i_servo_id;
    logic [ValueW-1:0] i_value_a;
    logic [ValueW-1:0] i_value_b;
    logic              o_strobe;
    logic [ByteW-1:0]  o_tx_byte;
    logic              o_last_byte;
    logic [ReplyW-1:0] o_reply_length;

    t_tx_beat          beats_due [$];
    logic              typed_chk_known;
    logic [ByteW-1:0]  typed_chk;
    int                mismatch_count;
    int                cycles_run;

    servo_instruction_packet_framer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_servo_id     (i_servo_id),
        .i_value_a      (i_value_a),
        .i_value_b      (i_value_b),
        .o_strobe       (o_strobe),
        .o_tx_byte      (o_tx_byte),
        .o_last_byte    (o_last_byte),
        .o_reply_length (o_reply_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void push_beat(input logic [ByteW-1:0] data, input logic last,
                                      input logic [ReplyW-1:0] reply);
        t_tx_beat b;
        b.data  = data;
        b.last  = last;
        b.reply = reply;
        beats_due.push_back(b);
    endfunction

    // Append the full instruction packet of one command to beats_due.
    function automatic void frame_packet(input t_op op, input logic [ByteW-1:0] id,
                                         input logic [ValueW-1:0] va,
                                         input logic [ValueW-1:0] vb);
        logic [ByteW-1:0]  params [5];
        logic [ByteW-1:0]  instr;
        logic [ByteW-1:0]  dest;
        logic [ByteW-1:0]  len;
        logic [ByteW-1:0]  sum;
        logic [ReplyW-1:0] reply;
        int                nparam;
        instr  = INSTR_WRITE;
        dest   = id;
        reply  = 4'd6;
        nparam = 0;
        for (int i = 0; i < 5; i++) params[i] = 8'h00;
        case (op)
            OP_GOTO: begin
                params[0] = ADDR_GOAL;
                params[1] = va[7:0];
                params[2] = va[15:8];
                params[3] = vb[7:0];
                params[4] = vb[15:8];
                nparam = 5;
            end
            OP_READ_MOVING: begin
                instr = INSTR_READ;
                params[0] = ADDR_MOVING;
                params[1] = 8'h01;
                nparam = 2;
                reply = 4'd7;
            end
            OP_READ_POS: begin
                instr = INSTR_READ;
                params[0] = ADDR_PRESENT;
                params[1] = 8'h02;
                nparam = 2;
                reply = 4'd8;
            end
            OP_ALARM: begin
                params[0] = ADDR_ALARM;
                params[1] = ALARM_MASK;
                nparam = 2;
                reply = 4'd0;
            end
            OP_TORQUE_ON: begin
                params[0] = ADDR_TORQUE_EN;
                params[1] = 8'h01;
                params[2] = 8'h00;
                nparam = 3;
            end
            OP_TORQUE_LIM: begin
                params[0] = ADDR_TORQUE_LM;
                params[1] = va[7:0];
                params[2] = va[15:8];
                nparam = 3;
            end
            OP_SET_ID: begin
                // new id goes out to every servo on the bus
                dest = BROADCAST_ID;
                params[0] = ADDR_ID;
                params[1] = va[7:0];
                nparam = 2;
            end
            default: begin
                instr = INSTR_RESET;
                reply = 4'd0;
            end
        endcase
        len = 8'(nparam + 2);
        sum = dest + len + instr;
        for (int i = 0; i < nparam; i++) sum = sum + params[i];
        push_beat(START_BYTE, 1'b0, reply);
        push_beat(START_BYTE, 1'b0, reply);
        push_beat(dest, 1'b0, reply);
        push_beat(len, 1'b0, reply);
        push_beat(instr, 1'b0, reply);
        for (int i = 0; i < nparam; i++) push_beat(params[i], 1'b0, reply);
        push_beat(~sum, 1'b1, reply);
    endfunction

    // Check strobed bytes first, then queue the packet of a command taken this edge.
    always @(posedge i_clk) begin : scoreboard
        t_tx_beat want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (beats_due.size() == 0) begin
                    $display("%0t: byte with no packet pending: expected none, actual %h",
                             $time, o_tx_byte);
                    mismatch_count++;
                end else begin
                    want = beats_due.pop_front();
                    if (o_tx_byte !== want.data) begin
                        $display("%0t: tx_byte expected %h actual %h",
                                 $time, want.data, o_tx_byte);
                        mismatch_count++;
                    end
                    if (o_last_byte !== want.last) begin
                        $display("%0t: last_byte expected %b actual %b",
                                 $time, want.last, o_last_byte);
                        mismatch_count++;
                    end
                    if (o_reply_length !== want.reply) begin
                        $display("%0t: reply_length expected %0d actual %0d",
                                 $time, want.reply, o_reply_length);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                frame_packet(t_op'(i_operation), i_servo_id, i_value_a, i_value_b);
                if (typed_chk_known) beats_due[beats_due.size() - 1].data = typed_chk;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("servo_instruction_packet_framer_top_test: done, errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(input t_op op, input logic [ByteW-1:0] id,
                            input logic [ValueW-1:0] va, input logic [ValueW-1:0] vb,
                            input logic chk_known, input logic [ByteW-1:0] chk,
                            input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_operation     <= op;
        i_servo_id      <= id;
        i_value_a       <= va;
        i_value_b       <= vb;
        typed_chk_known = chk_known;
        typed_chk       = chk;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [ValueW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       pick_value = 16'h0000;
            1:       pick_value = 16'hFFFF;
            default: pick_value = 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin : stimulus
        int               idle_pct [3];
        logic [ByteW-1:0] id;
        idle_pct        = '{12, 50, 0};
        mismatch_count  = 0;
        cycles_run      = 0;
        typed_chk_known = 1'b0;
        typed_chk       = 8'h00;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_operation     = '0;
        i_servo_id      = '0;
        i_value_a       = '0;
        i_value_b       = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_cmd(directed_cmds[r].op, directed_cmds[r].id, directed_cmds[r].va,
                     directed_cmds[r].vb, directed_cmds[r].chk_known,
                     directed_cmds[r].chk, 12);
        end

        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                // lean on the broadcast and all-ones ids now and then
                case ($urandom_range(0, 9))
                    0:       id = BROADCAST_ID;
                    1:       id = 8'hFF;
                    2:       id = 8'h00;
                    default: id = 8'($urandom_range(0, 255));
                endcase
                send_cmd(t_op'($urandom_range(0, 7)), id, pick_value(), pick_value(),
                         1'b0, 8'h00, idle_pct[phase]);
            end
        end
        start <= 1'b0;

        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("servo_instruction_packet_framer_top_test: done, clean");
        end else begin
            $display("servo_instruction_packet_framer_top_test: done, errors");
        end
        $finish;
    end

endmodule
